/* hdl/mlfd_pkg.sv */
`timescale 1ns / 1ps

package mlfd_pkg;

   localparam int MAC_WIDTH             = 48;
   localparam int PORT_WIDTH            = 3;
   localparam int MASK_WIDTH            = 8;
   localparam int NUM_PORTS             = 8;
   localparam int TABLE_ENTRIES_DEFAULT = 32;

   localparam logic ACTION_FORWARD = 1'b0;
   localparam logic ACTION_ADD     = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [MAC_WIDTH-1:0]  src_mac;
      logic [MAC_WIDTH-1:0]  dest_mac;
      logic [PORT_WIDTH-1:0] in_port;
   } req_type;

   typedef struct packed {
      logic [MASK_WIDTH-1:0] port_mask;
      logic                  flooded;
      logic                  learned;
      logic                  table_full;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic req_add;
      logic table_empty;
      logic last_issue;
   } status_type;

endpackage

/* hdl/mlfd_ram.sv */
`timescale 1ns / 1ps

module mlfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mlfd_ctrl.sv */
`timescale 1ns / 1ps

module mlfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mlfd_pkg::status_type status,
   output mlfd_pkg::cmd_type    cmd,
   output logic                 busy
);

   mlfd_pkg::state_type state_ff;
   mlfd_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlfd_pkg::ST_IDLE: begin
            if (start) begin
               // Add-entry items and frames on an empty table need no scan.
               if (status.req_add || status.table_empty) begin
                  state_in = mlfd_pkg::ST_UPDATE;
               end else begin
                  state_in = mlfd_pkg::ST_SCAN;
               end
            end
         end
         mlfd_pkg::ST_SCAN: begin
            if (status.last_issue) begin
               state_in = mlfd_pkg::ST_DRAIN;
            end
         end
         mlfd_pkg::ST_DRAIN: begin
            state_in = mlfd_pkg::ST_UPDATE;
         end
         mlfd_pkg::ST_UPDATE: begin
            state_in = mlfd_pkg::ST_IDLE;
         end
         default: begin
            state_in = mlfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.update = 1'b0;
      busy       = 1'b1;
      unique case (state_ff)
         mlfd_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         mlfd_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         mlfd_pkg::ST_DRAIN: begin
         end
         mlfd_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlfd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == mlfd_pkg::ST_DRAIN |-> $past(state_ff) == mlfd_pkg::ST_SCAN)
      else $error("drain state entered without a preceding scan");

endmodule

/* hdl/mlfd_datapath.sv */
`timescale 1ns / 1ps

module mlfd_datapath #(
   parameter int TABLE_ENTRIES = mlfd_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mlfd_pkg::req_type    req_item,
   input  mlfd_pkg::cmd_type    cmd,
   output mlfd_pkg::status_type status,
   output logic                 rsp_valid,
   output mlfd_pkg::rsp_type    rsp_item
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = mlfd_pkg::MAC_WIDTH + mlfd_pkg::PORT_WIDTH;

   mlfd_pkg::req_type           req_ff,       req_in;
   logic [CW-1:0]               count_ff,     count_in;
   logic [AW-1:0]               scan_ff,      scan_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic                        src_found_ff, src_found_in;
   logic                        dst_hit_ff,   dst_hit_in;
   logic [mlfd_pkg::PORT_WIDTH-1:0] dst_port_ff, dst_port_in;
   mlfd_pkg::rsp_type           rsp_ff,       rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [EW-1:0]                   rd_data;
   logic [mlfd_pkg::MAC_WIDTH-1:0]  rd_mac;
   logic [mlfd_pkg::PORT_WIDTH-1:0] rd_port;
   logic                            is_add;
   logic                            need_insert;
   logic                            has_room;
   logic                            wr_en;
   logic                            hit;
   logic [mlfd_pkg::PORT_WIDTH-1:0] port_sel;

   // Entries are only ever appended at the lowest free slot, so the valid
   // entries are always slots 0 to count_ff - 1.
   mlfd_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(count_ff)),
      .wr_data ({req_ff.src_mac, req_ff.in_port}),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   assign rd_mac  = rd_data[EW-1:mlfd_pkg::PORT_WIDTH];
   assign rd_port = rd_data[mlfd_pkg::PORT_WIDTH-1:0];

   assign status.req_add     = (req_item.action == mlfd_pkg::ACTION_ADD);
   assign status.table_empty = (count_ff == '0);
   assign status.last_issue  = ((CW + 1)'(scan_ff) + (CW + 1)'(1)) == (CW + 1)'(count_ff);

   assign is_add      = (req_ff.action == mlfd_pkg::ACTION_ADD);
   assign need_insert = is_add || !src_found_ff;
   assign has_room    = (count_ff != CW'(TABLE_ENTRIES));
   assign wr_en       = cmd.update && need_insert && has_room;

   // The entry just learned sits above every older one, so it only wins
   // when no older entry matched the destination.
   assign hit      = dst_hit_ff || (need_insert && has_room &&
                                    req_ff.dest_mac == req_ff.src_mac);
   assign port_sel = dst_hit_ff ? dst_port_ff : req_ff.in_port;

   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_valid_in = cmd.scan;
      src_found_in = src_found_ff;
      dst_hit_in   = dst_hit_ff;
      dst_port_in  = dst_port_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = cmd.update;

      if (cmd.load) begin
         req_in       = req_item;
         scan_in      = '0;
         src_found_in = 1'b0;
         dst_hit_in   = 1'b0;
      end

      if (cmd.scan) begin
         scan_in = scan_ff + AW'(1);
      end

      if (cmp_valid_ff) begin
         if (rd_mac == req_ff.src_mac) begin
            src_found_in = 1'b1;
         end
         if (!dst_hit_ff && rd_mac == req_ff.dest_mac) begin
            dst_hit_in  = 1'b1;
            dst_port_in = rd_port;
         end
      end

      if (cmd.update) begin
         if (wr_en) begin
            count_in = count_ff + CW'(1);
         end
         rsp_in.learned    = need_insert && has_room;
         rsp_in.table_full = need_insert && !has_room;
         rsp_in.flooded    = !is_add && !hit;
         for (int p = 0; p < mlfd_pkg::MASK_WIDTH; p++) begin
            if (is_add || p >= mlfd_pkg::NUM_PORTS) begin
               rsp_in.port_mask[p] = 1'b0;
            end else if (hit) begin
               rsp_in.port_mask[p] = (port_sel == mlfd_pkg::PORT_WIDTH'(p));
            end else begin
               rsp_in.port_mask[p] = (req_ff.in_port != mlfd_pkg::PORT_WIDTH'(p));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_ff      <= scan_in;
      src_found_ff <= src_found_in;
      dst_hit_ff   <= dst_hit_in;
      dst_port_ff  <= dst_port_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
      else $error("fill count exceeds table size");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.learned && rsp_ff.table_full))
      else $error("learned and table_full reported together");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.learned |-> count_ff == $past(count_ff) + CW'(1))
      else $error("learned entry did not advance the fill count");

endmodule

/* hdl/mac_learning_forward_decision_core.sv */
`timescale 1ns / 1ps

// Channel      Ports                         Transfer
// request      start, busy, req_item         start high while busy is low
// response     rsp_valid, rsp_item           rsp_valid high for one cycle
//
// An add-entry item, or a frame that arrives while the table is empty, goes
// from acceptance straight to the update state and the registered response
// strobe. Any other frame scans all N stored entries, drains, then updates:
// the table RAM is read one entry per cycle and each entry is compared
// against both source and destination MAC in the same pass.
// Synchronous reset empties the table by clearing its fill count.
// The response is shown for one cycle and cannot be stalled; a new request
// may be accepted in the same cycle that the previous response is shown.

module mac_learning_forward_decision_core #(
   parameter int TABLE_ENTRIES = mlfd_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mlfd_pkg::req_type req_item,
   output logic              rsp_valid,
   output mlfd_pkg::rsp_type rsp_item
);

   mlfd_pkg::cmd_type    cmd;
   mlfd_pkg::status_type status;

   mlfd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   mlfd_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* tb/mac_learning_forward_decision_core_test.sv */
`timescale 1ns / 1ps

module mac_learning_forward_decision_core_test;
   import mlfd_pkg::*;

   localparam int TABLE_SIZE  = TABLE_ENTRIES_DEFAULT;
   localparam int DRAIN_WAIT  = TABLE_SIZE + 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PORT_MAX    = (1 << PORT_WIDTH) - 1;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Shadow copy of the forwarding table. Nothing is ever removed, so the
   // used slots are always 0 .. fdb_fill-1.
   logic                  fdb_valid [TABLE_SIZE];
   logic [MAC_WIDTH-1:0]  fdb_mac   [TABLE_SIZE];
   logic [PORT_WIDTH-1:0] fdb_port  [TABLE_SIZE];
   int                    fdb_fill;

   rsp_type pending_decisions[$];
   int      idle_pct;
   int      error_count = 0;
   int      cycle_count = 0;
   int      frame_count = 0;
   int      add_count = 0;
   int      flood_count = 0;
   int      learn_count = 0;
   int      full_count = 0;
   int      decisions_seen = 0;

   mac_learning_forward_decision_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic int fdb_find(input logic [MAC_WIDTH-1:0] mac);
      for (int i = 0; i < TABLE_SIZE; i++)
         if (fdb_valid[i] && fdb_mac[i] == mac) return i;
      return -1;
   endfunction

   function automatic bit fdb_insert(input logic [MAC_WIDTH-1:0] mac,
                                     input logic [PORT_WIDTH-1:0] port);
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (!fdb_valid[i]) begin
            fdb_valid[i] = 1'b1;
            fdb_mac[i]   = mac;
            fdb_port[i]  = port;
            fdb_fill++;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Learning is done before the destination lookup, so a frame whose
   // destination equals its own new source already hits.
   function automatic rsp_type forward_decision(input req_type item);
      rsp_type r;
      int      hit;
      r = '0;
      if (item.action == ACTION_ADD) begin
         if (fdb_insert(item.src_mac, item.in_port)) r.learned = 1'b1;
         else r.table_full = 1'b1;
      end else begin
         if (fdb_find(item.src_mac) < 0) begin
            if (fdb_insert(item.src_mac, item.in_port)) r.learned = 1'b1;
            else r.table_full = 1'b1;
         end
         hit = fdb_find(item.dest_mac);
         if (hit >= 0) begin
            if (int'(fdb_port[hit]) < NUM_PORTS) r.port_mask[fdb_port[hit]] = 1'b1;
         end else begin
            r.flooded = 1'b1;
            for (int p = 0; p < NUM_PORTS && p < MASK_WIDTH; p++)
               if (p != int'(item.in_port)) r.port_mask[p] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [MAC_WIDTH-1:0] random_mac();
      logic [MAC_WIDTH-1:0] m;
      case ($urandom_range(19))
         0: m = '0;
         1: m = '1;
         default: m = MAC_WIDTH'({$urandom(), $urandom()});
      endcase
      return m;
   endfunction

   function automatic logic [MAC_WIDTH-1:0] known_mac();
      if (fdb_fill == 0) return random_mac();
      return fdb_mac[$urandom_range(fdb_fill - 1)];
   endfunction

   // Drives one transaction and records its expected decision once the
   // block is seen ready to take it. Returns at the accepting clock edge.
   task automatic send_item(input req_type item);
      rsp_type predicted;
      bit      taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         if (taken) begin
            predicted = forward_decision(item);
            pending_decisions.push_back(predicted);
            if (item.action == ACTION_ADD) add_count++;
            else frame_count++;
            flood_count += predicted.flooded;
            learn_count += predicted.learned;
            full_count  += predicted.table_full;
         end
         @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [MAC_WIDTH-1:0] src,
                             input logic [MAC_WIDTH-1:0] dst,
                             input logic [PORT_WIDTH-1:0] port);
      req_type item;
      item.action   = ACTION_FORWARD;
      item.src_mac  = src;
      item.dest_mac = dst;
      item.in_port  = port;
      send_item(item);
   endtask

   task automatic send_add(input logic [MAC_WIDTH-1:0] mac,
                           input logic [PORT_WIDTH-1:0] port);
      req_type item;
      item.action   = ACTION_ADD;
      item.src_mac  = mac;
      item.dest_mac = random_mac();
      item.in_port  = port;
      send_item(item);
   endtask

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         decisions_seen++;
         if (pending_decisions.size() == 0) begin
            error_count++;
            $display("%0t: response with no transaction outstanding: %p", $time, rsp_item);
         end else begin
            want = pending_decisions.pop_front();
            if (want.port_mask !== rsp_item.port_mask || want.flooded !== rsp_item.flooded ||
                want.learned !== rsp_item.learned || want.table_full !== rsp_item.table_full) begin
               error_count++;
               $display("%0t: mismatch: expected mask=%h flooded=%b learned=%b full=%b",
                        $time, want.port_mask, want.flooded, want.learned, want.table_full);
               $display("%0t:           actual   mask=%h flooded=%b learned=%b full=%b",
                        $time, rsp_item.port_mask, rsp_item.flooded, rsp_item.learned,
                        rsp_item.table_full);
            end
         end
      end
   end

   localparam logic [MAC_WIDTH-1:0] MAC_A = 48'h0200_0000_0001;
   localparam logic [MAC_WIDTH-1:0] MAC_B = 48'h0200_0000_0002;
   localparam logic [MAC_WIDTH-1:0] MAC_C = 48'h0200_0000_0003;
   localparam logic [MAC_WIDTH-1:0] MAC_D = 48'h0200_0000_0004;
   localparam logic [MAC_WIDTH-1:0] MAC_E = 48'h0200_0000_0005;

   // An empty table floods every frame, and the flood skips the ingress port.
   task automatic test_flood_on_empty_table;
      send_frame(MAC_A, MAC_B, 3'd0);
      send_frame('0, '1, 3'd7);
   endtask

   // Learned sources are found again; a known source keeps its first port.
   task automatic test_learned_lookup;
      send_frame(MAC_B, MAC_A, 3'd5);
      send_frame('1, '1, 3'd3);
      send_frame('0, '0, 3'd2);
      send_frame(MAC_A, MAC_B, 3'd6);
   endtask

   // Static entries are not checked for duplicates; the lowest slot wins.
   task automatic test_static_entries;
      send_add(MAC_C, 3'd6);
      send_add(MAC_A, 3'd4);
      send_frame(MAC_C, MAC_A, 3'd1);
      send_frame(MAC_D, MAC_C, 3'd4);
      send_frame(MAC_E, 48'h8000_0000_0000, 3'd1);
   endtask

   task automatic test_random_traffic(input int count, input int pct);
      req_type item;
      int      pick;
      idle_pct = pct;
      repeat (count) begin
         item.in_port = PORT_WIDTH'($urandom_range(PORT_MAX));
         if ($urandom_range(99) < 5) begin
            item.action   = ACTION_ADD;
            item.src_mac  = $urandom_range(1) ? known_mac() : random_mac();
            item.dest_mac = random_mac();
         end else begin
            item.action  = ACTION_FORWARD;
            item.src_mac = ($urandom_range(99) < 95) ? known_mac() : random_mac();
            pick = $urandom_range(99);
            if (pick < 55) item.dest_mac = known_mac();
            else if (pick < 70)
               item.dest_mac = known_mac() ^ (MAC_WIDTH'(1) << $urandom_range(MAC_WIDTH - 1));
            else item.dest_mac = random_mac();
         end
         send_item(item);
      end
   endtask

   // Fills whatever room is left, then checks that nothing more is learned.
   task automatic test_table_full;
      idle_pct = 20;
      while (fdb_fill < TABLE_SIZE)
         send_add(random_mac(), PORT_WIDTH'($urandom_range(PORT_MAX)));
      send_add(random_mac(), 3'd2);
      send_frame(48'h0a0b_0c0d_0e0f, 48'h0a0b_0c0d_0e10, 3'd4);
      send_frame(known_mac(), known_mac(), 3'd6);
   endtask

   task automatic finish_run;
      start <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Checked %0d responses for %0d frames and %0d static adds.",
               decisions_seen, frame_count, add_count);
      $display("Expected %0d floods, %0d learned entries and %0d table-full cases.",
               flood_count, learn_count, full_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      idle_pct = 0;
      fdb_fill = 0;
      foreach (fdb_valid[i]) begin
         fdb_valid[i] = 1'b0;
         fdb_mac[i]   = '0;
         fdb_port[i]  = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_flood_on_empty_table;
      test_learned_lookup;
      test_static_entries;
      test_random_traffic(440, 32);
      test_random_traffic(440, 73);
      test_random_traffic(440, 0);
      test_table_full;
      finish_run;
   end

endmodule
